// ----- src/step_segmenter_core_macros.svh -----
// Assertion helpers for the step segmenter checkers.
`ifndef STEP_SEGMENTER_CORE_MACROS_SVH
`define STEP_SEGMENTER_CORE_MACROS_SVH

// Same-cycle implication, idle while reset is high.
`define SSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle while reset is high.
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle after a reset edge.
`define SSC_ASSERT_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ----- src/stepseg_pkg.sv -----
package stepseg_pkg;

  localparam int MAG_W      = 16;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int HELD_STEPS_DEF   = 4;
  localparam int REPORT_AFTER_DEF = 3;

  localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MID   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LAST  = 2'd2;

  localparam logic [1:0] WALK_END   = 2'd0;
  localparam logic [1:0] WALK_START = 2'd1;
  localparam logic [1:0] WALK_MID   = 2'd2;

  localparam logic [1:0] SLOPE_NONE = 2'd0;
  localparam logic [1:0] SLOPE_UP   = 2'd1;
  localparam logic [1:0] SLOPE_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK_MAG         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK_MAG_INITIAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRIDE_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_TICKS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STRIDE_TICKS = 3'd4;

  localparam logic [TIME_W-1:0] DEFAULT_STRIDE_RESET = 32'd1843;

  typedef struct packed {
    logic [MAG_W-1:0]  acc_norm;
    logic [TIME_W-1:0] sample_time;
  } sample_t;

  typedef struct packed {
    logic [TIME_W-1:0] seg_start;
    logic [TIME_W-1:0] seg_stop;
    logic [KIND_W-1:0] seg_kind;
    logic              last_of_run;
  } seg_t;

  typedef struct packed {
    logic [MAG_W-1:0]  min_peak_mag;
    logic [MAG_W-1:0]  min_peak_mag_initial;
    logic [TIME_W-1:0] max_stride_ticks;
    logic [TIME_W-1:0] max_step_ticks;
    logic [TIME_W-1:0] default_stride_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_peak_mag:         16'd1126,
    min_peak_mag_initial: 16'd512,
    max_stride_ticks:     32'd2560,
    max_step_ticks:       32'd1331,
    default_stride_ticks: DEFAULT_STRIDE_RESET
  };

  // Walk state seen by the peak scorer.
  typedef struct packed {
    logic [1:0]        walk_mode;
    logic [TIME_W-1:0] expected_stride;
    logic [TIME_W-1:0] cur_start;
    logic [TIME_W-1:0] cur_stop;
    logic              step_mag_valid;
  } walk_view_t;

  // Step candidate raised by a positive peak.
  typedef struct packed {
    logic              take;
    logic [TIME_W-1:0] seg_s;
    logic [TIME_W-1:0] seg_e;
    logic [KIND_W-1:0] kind;
    logic              mag_ok;
    logic              steep;
  } peak_event_t;

endpackage

// ----- src/step_segmenter_core.sv -----
// An accepted item waits in the input register until the result buffer is free; processing it
// loads its results into the result buffer, which offers them from there on.
// Throughput: one item per cycle while items give at most one result and out_stall is low; the
// item closing a walk's held start gives REPORT_AFTER+1 results, one per unstalled cycle from the result buffer.
// Reset (rst, synchronous, active high): peak and walk state cleared, registers to defaults.
module step_segmenter_core #(
  parameter int HELD_STEPS   = stepseg_pkg::HELD_STEPS_DEF,
  parameter int REPORT_AFTER = stepseg_pkg::REPORT_AFTER_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  stepseg_pkg::sample_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output stepseg_pkg::seg_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [stepseg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stepseg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int OUT_SLOTS = REPORT_AFTER + 1;
  localparam int CNT_W     = $clog2(OUT_SLOTS + 1);

  stepseg_pkg::cfg_t                 cfg;
  logic                              s1_valid;
  stepseg_pkg::sample_t              s1_data;
  logic                              q_free;
  logic                              advance;
  stepseg_pkg::walk_view_t           walk;
  stepseg_pkg::peak_event_t          evt;
  logic [CNT_W-1:0]                  load_count;
  stepseg_pkg::seg_t [OUT_SLOTS-1:0] load_slots;

  assign advance  = s1_valid && q_free;
  assign in_stall = s1_valid && !q_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && !in_stall) || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= stepseg_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        stepseg_pkg::CFG_MIN_PEAK_MAG: begin
          cfg.min_peak_mag <= cfg_data[stepseg_pkg::MAG_W-1:0];
        end
        stepseg_pkg::CFG_MIN_PEAK_MAG_INITIAL: begin
          cfg.min_peak_mag_initial <= cfg_data[stepseg_pkg::MAG_W-1:0];
        end
        stepseg_pkg::CFG_MAX_STRIDE_TICKS: begin
          cfg.max_stride_ticks <= cfg_data[stepseg_pkg::TIME_W-1:0];
        end
        stepseg_pkg::CFG_MAX_STEP_TICKS: begin
          cfg.max_step_ticks <= cfg_data[stepseg_pkg::TIME_W-1:0];
        end
        stepseg_pkg::CFG_DEFAULT_STRIDE_TICKS: begin
          cfg.default_stride_ticks <= cfg_data[stepseg_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  stepseg_peak u_peak (
    .clk     (clk),
    .rst     (rst),
    .sample  (s1_data),
    .advance (advance),
    .cfg     (cfg),
    .walk    (walk),
    .evt     (evt)
  );

  stepseg_walk #(
    .HELD_STEPS   (HELD_STEPS),
    .REPORT_AFTER (REPORT_AFTER)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .evt            (evt),
    .default_stride (cfg.default_stride_ticks),
    .walk           (walk),
    .load_count     (load_count),
    .load_slots     (load_slots)
  );

  stepseg_outq #(
    .OUT_SLOTS (OUT_SLOTS)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .load_count (load_count),
    .load_slots (load_slots),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .free       (q_free)
  );

endmodule

// ----- src/stepseg_peak.sv -----
module stepseg_peak (
  input  logic                     clk,
  input  logic                     rst,
  input  stepseg_pkg::sample_t     sample,
  input  logic                     advance,
  input  stepseg_pkg::cfg_t        cfg,
  input  stepseg_pkg::walk_view_t  walk,
  output stepseg_pkg::peak_event_t evt
);

  localparam int MAG_W  = stepseg_pkg::MAG_W;
  localparam int TIME_W = stepseg_pkg::TIME_W;

  logic [MAG_W-1:0]  prev_norm;
  logic [TIME_W-1:0] prev_time;
  logic [1:0]        slope;
  logic [MAG_W-1:0]  pos_peak_mag;
  logic [MAG_W-1:0]  neg_peak_mag;
  logic [TIME_W-1:0] pos_peak_time;
  logic [TIME_W-1:0] neg_peak_time;
  logic [MAG_W-1:0]  step_peak_mag;

  logic                     rising;
  logic                     pos_evt;
  logic                     in_end;
  logic                     in_mid;
  logic [TIME_W-1:0]        half_stride;
  logic [TIME_W-1:0]        quarter_stride;
  logic [TIME_W-1:0]        since_neg;
  logic [TIME_W-1:0]        since_pos;
  logic [TIME_W-1:0]        since_stop;
  logic [TIME_W-1:0]        stride;
  logic [TIME_W-1:0]        stride_diff;
  logic signed [MAG_W:0]    min_s;
  logic signed [MAG_W:0]    min_init_s;
  logic signed [MAG_W:0]    drop_mag;
  logic signed [MAG_W:0]    rise_mag;
  logic                     neg_ok;
  logic                     big;
  logic                     init_big;
  logic                     mag_ok;
  logic                     consec_ok;
  logic                     near;
  logic                     period_ok;
  logic                     ending;
  logic                     meets;
  logic [MAG_W-1:0]         swing;
  logic signed [MAG_W+3:0]  swing_x4;
  logic signed [MAG_W+3:0]  rise_ext;
  logic signed [MAG_W+3:0]  rise_x3;

  assign rising  = sample.acc_norm >= prev_norm;
  assign pos_evt = !rising && (slope == stepseg_pkg::SLOPE_UP);
  assign in_end  = walk.walk_mode == stepseg_pkg::WALK_END;
  assign in_mid  = walk.walk_mode == stepseg_pkg::WALK_MID;

  assign half_stride    = walk.expected_stride >> 1;
  assign quarter_stride = walk.expected_stride >> 2;
  assign since_neg      = prev_time - neg_peak_time;
  assign since_pos      = prev_time - pos_peak_time;
  assign since_stop     = prev_time - walk.cur_stop;
  assign stride         = prev_time - walk.cur_start;
  assign stride_diff    = (stride >= walk.expected_stride) ? stride - walk.expected_stride
                                                           : walk.expected_stride - stride;

  assign min_s      = $signed({1'b0, cfg.min_peak_mag});
  assign min_init_s = $signed({1'b0, cfg.min_peak_mag_initial});
  assign drop_mag   = $signed({1'b0, step_peak_mag}) - $signed({1'b0, prev_norm});
  assign rise_mag   = $signed({1'b0, prev_norm}) - $signed({1'b0, neg_peak_mag});

  // Mid walk, a valley within a quarter stride of the last must be deep.
  assign neg_ok = !in_mid || (since_neg > half_stride) || (drop_mag > min_init_s) ||
                  ((half_stride - since_neg) < quarter_stride);

  assign big       = rise_mag > min_s;
  assign init_big  = rise_mag > min_init_s;
  assign mag_ok    = big || (in_end && init_big);
  assign consec_ok = !big && in_mid && walk.step_mag_valid;
  assign near      = in_mid && (stride_diff <= quarter_stride);
  assign period_ok = since_pos <= cfg.max_stride_ticks;
  assign ending    = !(since_stop <= cfg.max_step_ticks);
  assign meets     = period_ok &&
                     (mag_ok || ((neg_peak_time < walk.cur_stop) && consec_ok && near));

  // Steep first step: 4*|pos - cur| > 3*(cur - valley).
  assign swing    = (pos_peak_mag >= prev_norm) ? pos_peak_mag - prev_norm
                                                : prev_norm - pos_peak_mag;
  assign swing_x4 = $signed({2'b00, swing, 2'b00});
  assign rise_ext = {{3{rise_mag[MAG_W]}}, rise_mag};
  assign rise_x3  = rise_ext + (rise_ext <<< 1);

  always_comb begin
    evt.take   = pos_evt && (meets || (!in_end && ending));
    evt.seg_s  = (meets && in_end) ? pos_peak_time : walk.cur_stop;
    evt.seg_e  = (ending && !in_end && (walk.cur_stop > pos_peak_time)) ? pos_peak_time
                                                                       : prev_time;
    evt.kind   = stepseg_pkg::KIND_MID;
    if (meets && in_end) begin
      evt.kind = stepseg_pkg::KIND_FIRST;
    end else if (ending && !in_end) begin
      evt.kind = stepseg_pkg::KIND_LAST;
    end
    evt.mag_ok = mag_ok;
    evt.steep  = swing_x4 > rise_x3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_norm     <= '0;
      prev_time     <= '0;
      slope         <= stepseg_pkg::SLOPE_NONE;
      pos_peak_mag  <= '0;
      neg_peak_mag  <= '0;
      pos_peak_time <= '0;
      neg_peak_time <= '0;
      step_peak_mag <= '0;
    end else if (advance) begin
      if (rising) begin
        if ((slope == stepseg_pkg::SLOPE_DOWN) && neg_ok) begin
          neg_peak_time <= prev_time;
          neg_peak_mag  <= prev_norm;
        end
        slope <= stepseg_pkg::SLOPE_UP;
      end else begin
        if (slope == stepseg_pkg::SLOPE_UP) begin
          step_peak_mag <= prev_norm;
          pos_peak_mag  <= prev_norm;
          pos_peak_time <= prev_time;
        end
        slope <= stepseg_pkg::SLOPE_DOWN;
      end
      prev_norm <= sample.acc_norm;
      prev_time <= sample.sample_time;
    end
  end

endmodule

// ----- src/stepseg_walk.sv -----
module stepseg_walk #(
  parameter int HELD_STEPS   = stepseg_pkg::HELD_STEPS_DEF,
  parameter int REPORT_AFTER = stepseg_pkg::REPORT_AFTER_DEF,
  localparam int OUT_SLOTS   = REPORT_AFTER + 1,
  localparam int CNT_W       = $clog2(OUT_SLOTS + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  stepseg_pkg::peak_event_t             evt,
  input  logic [stepseg_pkg::TIME_W-1:0]       default_stride,
  output stepseg_pkg::walk_view_t              walk,
  output logic [CNT_W-1:0]                     load_count,
  output stepseg_pkg::seg_t [OUT_SLOTS-1:0]    load_slots
);

  localparam int TIME_W = stepseg_pkg::TIME_W;
  localparam int HC_W   = $clog2(REPORT_AFTER + 1);
  localparam int IDX_W  = $clog2(HELD_STEPS);

  logic [1:0]        walk_mode;
  logic [TIME_W-1:0] expected_stride;
  logic [TIME_W-1:0] cur_start;
  logic [TIME_W-1:0] cur_stop;
  logic              step_mag_valid;
  logic [HC_W-1:0]   held_count;
  stepseg_pkg::seg_t held [HELD_STEPS];

  logic [1:0]        walk_mode_next;
  logic [TIME_W-1:0] expected_stride_next;
  logic [HC_W-1:0]   held_count_next;
  logic              held_we;
  stepseg_pkg::seg_t held_wr;
  logic [HC_W-1:0]   fill;
  logic [TIME_W-1:0] step_stride;
  stepseg_pkg::seg_t cur_seg;

  assign walk.walk_mode       = walk_mode;
  assign walk.expected_stride = expected_stride;
  assign walk.cur_start       = cur_start;
  assign walk.cur_stop        = cur_stop;
  assign walk.step_mag_valid  = step_mag_valid;

  // A walk that is just starting counts from an empty hold buffer.
  assign fill        = (walk_mode == stepseg_pkg::WALK_END) ? '0 : held_count;
  assign step_stride = evt.seg_e - cur_start;

  always_comb begin
    cur_seg.seg_start   = evt.seg_s;
    cur_seg.seg_stop    = evt.seg_e;
    cur_seg.seg_kind    = evt.kind;
    cur_seg.last_of_run = 1'b1;

    held_wr.seg_start   = evt.seg_s;
    held_wr.seg_stop    = evt.seg_e;
    held_wr.seg_kind    = (fill == '0) ? stepseg_pkg::KIND_FIRST : evt.kind;
    held_wr.last_of_run = 1'b0;

    walk_mode_next       = walk_mode;
    expected_stride_next = expected_stride;
    held_count_next      = held_count;
    held_we              = 1'b0;
    load_count           = '0;
    load_slots           = '0;

    if (evt.take) begin
      if ((walk_mode != stepseg_pkg::WALK_END) && (evt.kind == stepseg_pkg::KIND_LAST)) begin
        // Walk over: report the last step only from mid walk, drop held steps.
        walk_mode_next       = stepseg_pkg::WALK_END;
        expected_stride_next = default_stride;
        if (walk_mode == stepseg_pkg::WALK_MID) begin
          load_count    = CNT_W'(1);
          load_slots[0] = cur_seg;
        end
      end else if (walk_mode == stepseg_pkg::WALK_MID) begin
        load_count           = CNT_W'(1);
        load_slots[0]        = cur_seg;
        expected_stride_next = step_stride;
      end else if (fill < HC_W'(REPORT_AFTER)) begin
        walk_mode_next  = stepseg_pkg::WALK_START;
        held_we         = 1'b1;
        held_count_next = ((fill == '0) && evt.steep) ? '0 : fill + 1'b1;
      end else begin
        // Release the held steps together with this one.
        for (int i = 0; i < REPORT_AFTER; i++) begin
          load_slots[i] = held[i];
        end
        load_slots[REPORT_AFTER] = cur_seg;
        load_count               = CNT_W'(OUT_SLOTS);
        walk_mode_next           = stepseg_pkg::WALK_MID;
        expected_stride_next     = step_stride;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_mode       <= stepseg_pkg::WALK_END;
      expected_stride <= stepseg_pkg::DEFAULT_STRIDE_RESET;
      cur_start       <= '0;
      cur_stop        <= '0;
      step_mag_valid  <= 1'b0;
      held_count      <= '0;
    end else if (advance) begin
      walk_mode       <= walk_mode_next;
      expected_stride <= expected_stride_next;
      held_count      <= held_count_next;
      if (evt.take) begin
        cur_start      <= evt.seg_s;
        cur_stop       <= evt.seg_e;
        step_mag_valid <= evt.mag_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_we) begin
      held[IDX_W'(fill)] <= held_wr;
    end
  end

endmodule

// ----- src/stepseg_outq.sv -----
module stepseg_outq #(
  parameter int OUT_SLOTS = stepseg_pkg::REPORT_AFTER_DEF + 1,
  localparam int CNT_W    = $clog2(OUT_SLOTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [CNT_W-1:0]                  load_count,
  input  stepseg_pkg::seg_t [OUT_SLOTS-1:0] load_slots,
  input  logic                              out_stall,
  output logic                              out_valid,
  output stepseg_pkg::seg_t                 out_data,
  output logic                              free
);

  logic [CNT_W-1:0]                  count;
  stepseg_pkg::seg_t [OUT_SLOTS-1:0] slots;
  logic                              take;

  assign out_valid = count != '0;
  assign out_data  = slots[0];
  assign take      = out_valid && !out_stall;
  // Free once the buffer is empty or its final entry leaves this cycle.
  assign free      = (count == '0) || ((count == CNT_W'(1)) && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_count;
    end else if (take) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_slots;
    end else if (take) begin
      for (int i = 0; i < OUT_SLOTS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

endmodule

// ----- src/stepseg_check.sv -----
`include "step_segmenter_core_macros.svh"

module stepseg_check (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input stepseg_pkg::seg_t out_data
);

  `SSC_ASSERT_RST(a_out_idle_after_rst, clk, rst, !out_valid, "result offered right after reset")
  `SSC_ASSERT_RST(a_in_open_after_rst, clk, rst, !in_stall, "input stalled right after reset")
  `SSC_ASSERT_NOW(a_stall_needs_backlog, clk, rst, in_stall, out_valid, "input stalled with no result pending")
  `SSC_ASSERT_NEXT(a_run_continues, clk, rst, out_valid && !out_stall && !out_data.last_of_run, out_valid, "result run broken before its last entry")
  `SSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind step_segmenter_core stepseg_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
